// ----- rtl/odtf_pkg.sv -----
// Shared types and constants for the odometry-to-field pose transform.
// Used by odtf_cordic, odtf_pipe and odom_to_field_pose_transform.
package odtf_pkg;

    localparam int TRIG_WIDTH      = 18;
    localparam int TRIG_ONE        = 65536;
    localparam int CORDIC_WIDTH    = 34;
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int ATAN_ENTRIES    = 24;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ANCHOR_X       = 2'd0,
        CFG_ANCHOR_Y       = 2'd1,
        CFG_ANCHOR_HEADING = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_RUN,
        CS_DONE
    } t_cordic_state;

    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0] cosine;
        logic signed [TRIG_WIDTH-1:0] sine;
    } t_trig;

    typedef struct packed {
        logic [2:0] stage_valid;
    } t_pipe_stat;

    // atan(2^-i) in binary-angle units of 2^32 per turn
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/odom_to_field_pose_transform.sv -----
// Top level of the odometry-to-field pose transform.
// Holds the anchor registers; instantiates odtf_cordic and odtf_pipe (odtf_pkg).
//
// A pose word enters every cycle unless o_odom_stall is high, and its field pose leaves
// through a three-stage pipeline (products, rounded sums, offset and saturation); each stage
// holds a word under output stall while earlier empty stages keep filling. A write of
// anchor_heading starts the CORDIC unit, which runs CORDIC_STEPS rotations (capped at
// 24), one per cycle, then rounds and stores the result in its done state; while it
// runs, the pose input and configuration port are stalled. Writes of anchor_x and anchor_y
// go straight into their registers. After reset the cosine is exactly one and the sine zero.
module odom_to_field_pose_transform #(
    parameter int POSITION_WIDTH = 32,
    parameter int ANGLE_WIDTH    = 16,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [odtf_pkg::CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  logic [((POSITION_WIDTH > ANGLE_WIDTH) ? POSITION_WIDTH : ANGLE_WIDTH)-1:0]
                                                     i_cfg_data,
    input  logic                                     i_odom_valid,
    output logic                                     o_odom_stall,
    input  logic signed [POSITION_WIDTH-1:0]         i_odom_x,
    input  logic signed [POSITION_WIDTH-1:0]         i_odom_y,
    input  logic signed [ANGLE_WIDTH-1:0]            i_odom_heading,
    output logic                                     o_field_valid,
    input  logic                                     i_field_stall,
    output logic signed [POSITION_WIDTH-1:0]         o_field_x,
    output logic signed [POSITION_WIDTH-1:0]         o_field_y,
    output logic signed [ANGLE_WIDTH-1:0]            o_field_heading
);
    import odtf_pkg::*;

    logic signed [POSITION_WIDTH-1:0] r_anchor_x, r_anchor_y, n_anchor_x, n_anchor_y;
    logic signed [ANGLE_WIDTH-1:0]    r_anchor_heading, n_anchor_heading;
    logic cfg_wr, heading_wr, cordic_busy;
    t_trig      trig;
    t_pipe_stat stat;

    assign o_cfg_ready = !cordic_busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign heading_wr  = cfg_wr && (i_cfg_index == CFG_ANCHOR_HEADING);

    always_comb begin
        n_anchor_x       = r_anchor_x;
        n_anchor_y       = r_anchor_y;
        n_anchor_heading = r_anchor_heading;
        if (cfg_wr) begin
            if (i_cfg_index == CFG_ANCHOR_X) n_anchor_x = i_cfg_data[POSITION_WIDTH-1:0];
            if (i_cfg_index == CFG_ANCHOR_Y) n_anchor_y = i_cfg_data[POSITION_WIDTH-1:0];
            if (heading_wr) n_anchor_heading = i_cfg_data[ANGLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_x       <= '0;
            r_anchor_y       <= '0;
            r_anchor_heading <= '0;
        end else begin
            r_anchor_x       <= n_anchor_x;
            r_anchor_y       <= n_anchor_y;
            r_anchor_heading <= n_anchor_heading;
        end
    end

    odtf_cordic #(
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (heading_wr),
        .i_heading (i_cfg_data[ANGLE_WIDTH-1:0]),
        .o_busy    (cordic_busy),
        .o_trig    (trig)
    );

    odtf_pipe #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .ANGLE_WIDTH    (ANGLE_WIDTH)
    ) u_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_odom_valid),
        .o_stall          (o_odom_stall),
        .i_odom_x         (i_odom_x),
        .i_odom_y         (i_odom_y),
        .i_odom_heading   (i_odom_heading),
        .i_trig           (trig),
        .i_anchor_x       (r_anchor_x),
        .i_anchor_y       (r_anchor_y),
        .i_anchor_heading (r_anchor_heading),
        .i_hold           (cordic_busy),
        .o_valid          (o_field_valid),
        .i_stall          (i_field_stall),
        .o_field_x        (o_field_x),
        .o_field_y        (o_field_y),
        .o_field_heading  (o_field_heading),
        .o_stat           (stat)
    );

    a_heading_starts_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        heading_wr |=> !o_cfg_ready)
        else $error("heading write did not start trig update");

    a_no_pose_during_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> o_odom_stall)
        else $error("pose accepted while trig update runs");

    a_full_pipe_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&stat.stage_valid && i_field_stall) |-> o_odom_stall)
        else $error("pose accepted into a full stalled pipeline");

    a_output_tracks_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_field_valid == stat.stage_valid[2])
        else $error("output valid out of step with last stage");

endmodule

// ----- rtl/odtf_cordic.sv -----
// Iterative rotation-mode CORDIC: cosine and sine of the anchor heading.
// One micro-rotation per cycle; depends on odtf_pkg.
module odtf_cordic #(
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ANGLE_WIDTH-1:0] i_heading,
    output logic                   o_busy,
    output odtf_pkg::t_trig        o_trig
);
    import odtf_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int STEP_W = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

    t_cordic_state r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic signed [CORDIC_WIDTH-1:0] r_x, r_y, r_z;
    logic signed [CORDIC_WIDTH-1:0] n_x, n_y, n_z;
    logic signed [CORDIC_WIDTH-1:0] x0, z0, dx, dy, at;
    logic [31:0] z32, zoff, zrot;
    logic flip, load, step_en, commit, last_step;
    t_trig r_trig;

    function automatic logic signed [TRIG_WIDTH-1:0] round_q16(
        input logic signed [CORDIC_WIDTH-1:0] v
    );
        logic signed [CORDIC_WIDTH-1:0] r;
        logic signed [CORDIC_WIDTH-1:0] q;
        r = v + CORDIC_WIDTH'(8192);
        q = r >>> 14;
        if (&q[CORDIC_WIDTH-1:TRIG_WIDTH-1] || ~|q[CORDIC_WIDTH-1:TRIG_WIDTH-1]) begin
            return q[TRIG_WIDTH-1:0];
        end
        return {q[CORDIC_WIDTH-1], {(TRIG_WIDTH-1){~q[CORDIC_WIDTH-1]}}};
    endfunction

    always_comb begin
        z32  = {i_heading, {(32-ANGLE_WIDTH){1'b0}}};
        zoff = z32 - 32'h4000_0000;
        flip = !zoff[31];
        zrot = flip ? (z32 - 32'h8000_0000) : z32;
        z0   = {{(CORDIC_WIDTH-32){zrot[31]}}, zrot};
        x0   = flip ? -CORDIC_WIDTH'(CORDIC_GAIN_Q30) : CORDIC_WIDTH'(CORDIC_GAIN_Q30);
    end

    always_comb begin
        last_step = (r_step == STEP_W'(NSTEPS - 1));
        dx = r_y >>> r_step;
        dy = r_x >>> r_step;
        at = {{(CORDIC_WIDTH-32){1'b0}}, atan_turn32(5'(r_step))};
        if (!r_z[CORDIC_WIDTH-1]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - at;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + at;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE: if (i_start) n_state = CS_RUN;
            CS_RUN:  if (last_step) n_state = CS_DONE;
            CS_DONE: n_state = CS_IDLE;
            default: n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        load    = 1'b0;
        step_en = 1'b0;
        commit  = 1'b0;
        o_busy  = 1'b1;
        unique case (r_state)
            CS_IDLE: begin
                load   = i_start;
                o_busy = 1'b0;
            end
            CS_RUN:  step_en = 1'b1;
            CS_DONE: commit = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= CS_IDLE;
            r_trig.cosine <= TRIG_WIDTH'(TRIG_ONE);
            r_trig.sine   <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_trig.cosine <= round_q16(r_x);
                r_trig.sine   <= round_q16(r_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x    <= x0;
            r_y    <= '0;
            r_z    <= z0;
            r_step <= '0;
        end else if (step_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_trig = r_trig;

endmodule

// ----- rtl/odtf_pipe.sv -----
// Three-stage pose datapath: multiply, sum and round, shift, offset and saturate.
// Depends on odtf_pkg for the trig and status types.
module odtf_pipe #(
    parameter int POSITION_WIDTH = 32,
    parameter int ANGLE_WIDTH    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [POSITION_WIDTH-1:0] i_odom_x,
    input  logic signed [POSITION_WIDTH-1:0] i_odom_y,
    input  logic signed [ANGLE_WIDTH-1:0]    i_odom_heading,
    input  odtf_pkg::t_trig                  i_trig,
    input  logic signed [POSITION_WIDTH-1:0] i_anchor_x,
    input  logic signed [POSITION_WIDTH-1:0] i_anchor_y,
    input  logic signed [ANGLE_WIDTH-1:0]    i_anchor_heading,
    input  logic                             i_hold,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [POSITION_WIDTH-1:0] o_field_x,
    output logic signed [POSITION_WIDTH-1:0] o_field_y,
    output logic signed [ANGLE_WIDTH-1:0]    o_field_heading,
    output odtf_pkg::t_pipe_stat             o_stat
);
    import odtf_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int MW = PW + TRIG_WIDTH;
    localparam int SW = MW + 1;
    localparam int QW = PW + 4;
    localparam logic signed [SW-1:0] RND = SW'(32768);

    logic adv1, adv2, adv3, acc;
    logic signed [TRIG_WIDTH-1:0] c, s;

    logic r_v1, r_v2, r_v3;
    logic signed [MW-1:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [MW-1:0] n_pxc, n_pys, n_pxs, n_pyc;
    logic signed [ANGLE_WIDTH-1:0] r_h1, r_h2, r_h3, n_h1;
    logic signed [SW-1:0] r_sx, r_sy, n_sx, n_sy;
    logic signed [SW-1:0] shx, shy;
    logic [QW-1:0] sumx, sumy;
    logic signed [PW-1:0] r_fx, r_fy, n_fx, n_fy;

    function automatic logic [PW-1:0] sat(input logic [QW-1:0] v);
        if (&v[QW-1:PW-1] || ~|v[QW-1:PW-1]) begin
            return v[PW-1:0];
        end
        return {v[QW-1], {(PW-1){~v[QW-1]}}};
    endfunction

    assign adv3    = !r_v3 || !i_stall;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1 || i_hold;
    assign acc     = i_valid && !o_stall;

    always_comb begin
        c     = i_trig.cosine;
        s     = i_trig.sine;
        n_pxc = MW'(i_odom_x) * MW'(c);
        n_pys = MW'(i_odom_y) * MW'(s);
        n_pxs = MW'(i_odom_x) * MW'(s);
        n_pyc = MW'(i_odom_y) * MW'(c);
        n_h1  = i_anchor_heading + i_odom_heading;
    end

    always_comb begin
        n_sx = SW'(r_pxc) - SW'(r_pys) + RND;
        n_sy = SW'(r_pxs) + SW'(r_pyc) + RND;
    end

    always_comb begin
        shx  = r_sx >>> 16;
        shy  = r_sy >>> 16;
        sumx = {shx[PW+2], shx[PW+2:0]} + {{4{i_anchor_x[PW-1]}}, i_anchor_x};
        sumy = {shy[PW+2], shy[PW+2:0]} + {{4{i_anchor_y[PW-1]}}, i_anchor_y};
        n_fx = sat(sumx);
        n_fy = sat(sumy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= acc;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_pxc <= n_pxc;
            r_pys <= n_pys;
            r_pxs <= n_pxs;
            r_pyc <= n_pyc;
            r_h1  <= n_h1;
        end
        if (adv2) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_h2 <= r_h1;
        end
        if (adv3) begin
            r_fx <= n_fx;
            r_fy <= n_fy;
            r_h3 <= r_h2;
        end
    end

    assign o_valid          = r_v3;
    assign o_field_x        = r_fx;
    assign o_field_y        = r_fy;
    assign o_field_heading  = r_h3;
    assign o_stat.stage_valid = {r_v3, r_v2, r_v1};

endmodule

// ----- verif/odom_to_field_pose_transform_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for odom_to_field_pose_transform: a directed table, then
// extreme and randomized anchor settings with pose streams, checked against table values or a local predictor.
// Depends on rtl/odtf_pkg.sv and the block's RTL.
module odom_to_field_pose_transform_tb;

    import odtf_pkg::*;

    localparam int POS_W            = 32;
    localparam int ANG_W            = 16;
    localparam int CORDIC_STEPS     = 16;
    localparam int ROTATIONS        = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int N_PHASES         = 8;
    localparam int PHASE_POSES      = 120;
    localparam int N_DIRECTED       = 29;
    localparam int TIMEOUT_NS       = 2_000_000;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [ANG_W-1:0] heading;
    } t_field_pose;

    typedef enum {ROW_POSE, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [CFG_INDEX_WIDTH-1:0] idx;
        logic [POS_W-1:0]           data;
        logic [POS_W-1:0]           x;
        logic [POS_W-1:0]           y;
        logic [ANG_W-1:0]           h;
        bit                         typed;
        logic [POS_W-1:0]           ex;
        logic [POS_W-1:0]           ey;
        logic [ANG_W-1:0]           eh;
    } t_dir_row;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_cfg_valid    = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  i_cfg_index    = CFG_ANCHOR_X;
    logic [POS_W-1:0]            i_cfg_data     = '0;
    logic                        i_odom_valid   = 1'b0;
    logic                        o_odom_stall;
    logic signed [POS_W-1:0]     i_odom_x       = '0;
    logic signed [POS_W-1:0]     i_odom_y       = '0;
    logic signed [ANG_W-1:0]     i_odom_heading = '0;
    logic                        o_field_valid;
    logic                        i_field_stall  = 1'b0;
    logic signed [POS_W-1:0]     o_field_x;
    logic signed [POS_W-1:0]     o_field_y;
    logic signed [ANG_W-1:0]     o_field_heading;

    logic signed [POS_W-1:0] anchor_x_r       = '0;
    logic signed [POS_W-1:0] anchor_y_r       = '0;
    logic [ANG_W-1:0]        anchor_heading_r = '0;
    longint                  trig_cos         = TRIG_ONE;
    longint                  trig_sin         = 0;

    t_field_pose expected_poses[$];
    int          fail_count         = 0;
    int          words_checked      = 0;
    int          register_writes    = 0;
    int          idle_pct           = 20;
    int          long_hold_requests = 0;
    int          long_holds_served  = 0;
    int          hold_left          = 0;
    int          burst_left         = 0;

    longint atan_step_angle [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    t_dir_row directed_rows [N_DIRECTED] = '{
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h0, 32'h0, 16'h0, 1'b1, 32'h0, 32'h0, 16'h0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff,
          1'b1, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h8000_0000, 32'h7fff_ffff, 16'h8000,
          1'b1, 32'h8000_0000, 32'h7fff_ffff, 16'h8000},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h0000_3039, 32'hffff_fd4a, 16'h0064,
          1'b1, 32'h0000_3039, 32'hffff_fd4a, 16'h0064},
        '{ROW_WRITE, CFG_ANCHOR_X, 32'h7fff_0000, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h7fff_ffff, 32'h0, 16'h0,
          1'b1, 32'h7fff_ffff, 32'h0, 16'h0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h0001_0000, 32'h5, 16'h1,
          1'b1, 32'h7fff_ffff, 32'h5, 16'h1},
        '{ROW_WRITE, CFG_ANCHOR_Y, 32'h8000_0000, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h8000_0000, 32'h8000_0000, 16'h0,
          1'b1, 32'hffff_0000, 32'h8000_0000, 16'h0},
        '{ROW_WRITE, CFG_UNUSED, 32'hffff_ffff, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h0, 32'hffff_ffff, 16'h7fff,
          1'b1, 32'h7fff_0000, 32'h8000_0000, 16'h7fff},
        '{ROW_WRITE, CFG_ANCHOR_HEADING, 32'h4000, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h0001_0000, 32'h0, 16'h4000, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff,
          1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h8000_0000, 32'h8000_0000, 16'h8000,
          1'b0, '0, '0, '0},
        '{ROW_WRITE, CFG_ANCHOR_HEADING, 32'h8000, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff,
          1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h1234_5678, 32'hfedc_ba98, 16'h0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, CFG_ANCHOR_HEADING, 32'h7fff, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h8000_0000, 32'h7fff_ffff, 16'h1, 1'b0, '0, '0, '0},
        '{ROW_WRITE, CFG_ANCHOR_HEADING, 32'h0, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h0001_0000, 32'h0001_0000, 16'h0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, CFG_ANCHOR_HEADING, 32'hc000, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'hffff_0000, 32'h0003_0000, 16'h8000,
          1'b0, '0, '0, '0},
        '{ROW_WRITE, CFG_ANCHOR_X, 32'h0, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, CFG_ANCHOR_Y, 32'h0, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, CFG_ANCHOR_HEADING, 32'h2000, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0, 1'b0, '0, '0, '0},
        '{ROW_POSE, CFG_ANCHOR_X, '0, 32'h8000_0000, 32'h7fff_ffff, 16'h1234,
          1'b0, '0, '0, '0}
    };

    odom_to_field_pose_transform #(
        .POSITION_WIDTH (POS_W),
        .ANGLE_WIDTH    (ANG_W),
        .CORDIC_STEPS   (CORDIC_STEPS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_odom_valid    (i_odom_valid),
        .o_odom_stall    (o_odom_stall),
        .i_odom_x        (i_odom_x),
        .i_odom_y        (i_odom_y),
        .i_odom_heading  (i_odom_heading),
        .o_field_valid   (o_field_valid),
        .i_field_stall   (i_field_stall),
        .o_field_x       (o_field_x),
        .o_field_y       (o_field_y),
        .o_field_heading (o_field_heading)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void load_anchor_heading(input logic [ANG_W-1:0] h);
        logic [31:0] z;
        logic [31:0] zoff;
        longint      x;
        longint      y;
        longint      zs;
        longint      dx;
        longint      dy;
        z    = {h, {(32-ANG_W){1'b0}}};
        x    = CORDIC_GAIN_Q30;
        y    = 0;
        zoff = z - 32'h4000_0000;
        if (zoff < 32'h8000_0000) begin
            z = z - 32'h8000_0000;
            x = -x;
        end
        zs = longint'($signed(z));
        for (int i = 0; i < ROTATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (zs >= 0) begin
                x  = x - dx;
                y  = y + dy;
                zs = zs - atan_step_angle[i];
            end else begin
                x  = x + dx;
                y  = y - dy;
                zs = zs + atan_step_angle[i];
            end
        end
        trig_cos = (x + 8192) >>> 14;
        trig_sin = (y + 8192) >>> 14;
        if (trig_cos > 131071) trig_cos = 131071;
        if (trig_cos < -131072) trig_cos = -131072;
        if (trig_sin > 131071) trig_sin = 131071;
        if (trig_sin < -131072) trig_sin = -131072;
    endfunction

    function automatic logic signed [POS_W-1:0] saturate_position(input longint v);
        longint pmax;
        longint pmin;
        pmax = (longint'(1) <<< (POS_W - 1)) - 1;
        pmin = -(longint'(1) <<< (POS_W - 1));
        if (v > pmax) return pmax[POS_W-1:0];
        if (v < pmin) return pmin[POS_W-1:0];
        return v[POS_W-1:0];
    endfunction

    function automatic t_field_pose predict_field_pose(input logic signed [POS_W-1:0] ox,
                                                       input logic signed [POS_W-1:0] oy,
                                                       input logic signed [ANG_W-1:0] oh);
        t_field_pose p;
        longint      rx;
        longint      ry;
        rx = (longint'(ox) * trig_cos - longint'(oy) * trig_sin + 32768) >>> 16;
        ry = (longint'(ox) * trig_sin + longint'(oy) * trig_cos + 32768) >>> 16;
        p.x       = saturate_position(longint'(anchor_x_r) + rx);
        p.y       = saturate_position(longint'(anchor_y_r) + ry);
        p.heading = anchor_heading_r + oh;
        return p;
    endfunction

    function automatic logic [POS_W-1:0] random_position();
        logic [POS_W-1:0] v;
        case ($urandom_range(0, 9))
            0:          v = 32'h7fff_ffff;
            1:          v = 32'h8000_0000;
            2, 3, 4, 5: v = $urandom;
            default:    v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
        return v;
    endfunction

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [POS_W-1:0] data);
        i_odom_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ANCHOR_X:       anchor_x_r = data;
            CFG_ANCHOR_Y:       anchor_y_r = data;
            CFG_ANCHOR_HEADING: begin
                anchor_heading_r = data[ANG_W-1:0];
                load_anchor_heading(data[ANG_W-1:0]);
            end
            default: ;
        endcase
        register_writes++;
    endtask

    task automatic send_pose(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [ANG_W-1:0] h, input t_field_pose want);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            i_odom_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_odom_valid   <= 1'b1;
        i_odom_x       <= x;
        i_odom_y       <= y;
        i_odom_heading <= h;
        do @(posedge i_clk); while (o_odom_stall);
        expected_poses.push_back(want);
    endtask

    // receiver: long hold on request, otherwise random stall bursts
    always @(posedge i_clk) begin
        if (long_hold_requests != long_holds_served) begin
            long_holds_served++;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_field_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_field_stall <= 1'b1;
        end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            burst_left = $urandom_range(0, 2);
            i_field_stall <= 1'b1;
        end else begin
            i_field_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_fields
        t_field_pose want;
        if (i_rst_n && o_field_valid && !i_field_stall) begin
            if (expected_poses.size() == 0) begin
                $error("field pose word with none expected");
                fail_count++;
            end else begin
                want = expected_poses.pop_front();
                words_checked++;
                if (o_field_x !== want.x) begin
                    $error("field_x: expected %0d, got %0d", want.x, o_field_x);
                    fail_count++;
                end
                if (o_field_y !== want.y) begin
                    $error("field_y: expected %0d, got %0d", want.y, o_field_y);
                    fail_count++;
                end
                if (o_field_heading !== want.heading) begin
                    $error("field_heading: expected %0d, got %0d", want.heading,
                           o_field_heading);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_field_pose      want;
        logic [POS_W-1:0] ax;
        logic [POS_W-1:0] ay;
        logic [POS_W-1:0] hd;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [ANG_W-1:0] ph_h;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                write_register(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                if (directed_rows[r].typed) begin
                    want.x       = directed_rows[r].ex;
                    want.y       = directed_rows[r].ey;
                    want.heading = directed_rows[r].eh;
                end else begin
                    want = predict_field_pose(directed_rows[r].x, directed_rows[r].y,
                                              directed_rows[r].h);
                end
                send_pose(directed_rows[r].x, directed_rows[r].y, directed_rows[r].h, want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    ax = 32'h7fff_ffff;
                    ay = 32'h7fff_ffff;
                    hd = 32'h7fff;
                end
                1: begin
                    ax = 32'h8000_0000;
                    ay = 32'h8000_0000;
                    hd = 32'h8000;
                end
                default: begin
                    ax = random_position();
                    ay = random_position();
                    hd = $urandom;
                end
            endcase
            write_register(CFG_ANCHOR_X, ax);
            write_register(CFG_ANCHOR_Y, ay);
            write_register(CFG_ANCHOR_HEADING, hd);
            if (ph % 3 == 1) write_register(CFG_UNUSED, $urandom);
            idle_pct = (ph == N_PHASES - 1) ? 0 : $urandom_range(0, 40);
            if (ph == 2 || ph == 5) long_hold_requests++;
            for (int n = 0; n < PHASE_POSES; n++) begin
                px = random_position();
                py = random_position();
                case ($urandom_range(0, 7))
                    0:       ph_h = 16'h7fff;
                    1:       ph_h = 16'h8000;
                    default: ph_h = $urandom;
                endcase
                send_pose(px, py, ph_h, predict_field_pose(px, py, ph_h));
            end
        end
        i_odom_valid <= 1'b0;

        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Summary: %0d field pose words checked after %0d register writes,",
                 words_checked, register_writes);
        $display("  with saturation, heading wrap, ignored index and long output holds.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
